>>> design/swma_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_pkg
// Shared sizes, codes and control types of the stack with middle access.
// ---------------------------------------------------------------------------
package swma_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int DEPTH_W     = 7;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH       = 2'd0,
    CMD_POP        = 2'd1,
    CMD_READ_MID   = 2'd2,
    CMD_DELETE_MID = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK    = 2'd0,
    RS_EMPTY = 2'd1,
    RS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    push_write;   // write push value at the top, count up
    logic    pop_read;     // read the top entry, count down
    logic    mid_read;     // read the middle entry, latch its index
    logic    count_down;   // count down after a middle delete
    logic    shift_write;  // move one entry down, advance the index
    logic    load_result;  // load the response register
    status_t res_status;
    logic    res_from_ram; // response value from RAM read data, else zero
  } dp_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic more;      // an entry sits above the one at the shift index
    logic out_busy;  // response held and not taken this cycle
  } dp_stat_t;

endpackage

>>> design/swma_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_req_if / swma_rsp_if
// Valid/ready channels for stack commands and their responses.
// ---------------------------------------------------------------------------
interface swma_req_if;
  logic                               valid;
  logic                               ready;
  logic [swma_pkg::CMD_W-1:0]         command;
  logic signed [swma_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

interface swma_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [swma_pkg::STATUS_W-1:0]      status;
  logic signed [swma_pkg::VALUE_W-1:0] result_value;
  logic [swma_pkg::DEPTH_W-1:0]       depth_after;

  modport source (output valid, output status, output result_value, output depth_after,
                  input ready);
  modport sink (input valid, input status, input result_value, input depth_after,
                output ready);
endinterface

>>> design/stack_with_middle_access_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_with_middle_access_core
// Bounded LIFO stack with read and delete of the middle entry.
// ---------------------------------------------------------------------------
// Commands arrive on the request channel (push, pop, read middle, delete
// middle); each one returns exactly one beat on the response channel with a
// status, a value and the depth after the command.
// The block works on one command at a time. A push, and any command refused
// as empty or full, has its response registered at accept. Pop and read
// middle make one read of the entry RAM, whose data is registered and loads
// the response. Delete middle reads the middle entry the same way; after
// the read, every entry above the middle moves down one slot per cycle
// through the single RAM port pair.
// The response register holds a beat until it is taken; while it is stalled
// the request channel is not ready. A new command is taken in the same cycle
// as the held response drains.
// Reset clears the entry count and the response valid; the RAM contents are
// not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module stack_with_middle_access_core (
  input  logic         clk,
  input  logic         rst,
  swma_req_if.sink     request,
  swma_rsp_if.source   response
);

  swma_pkg::dp_ctrl_t ctrl;
  swma_pkg::dp_stat_t stat;
  logic               ready;

  assign request.ready = ready;

  swma_controller u_controller (
    .clk     (clk),
    .rst     (rst),
    .valid   (request.valid),
    .command (request.command),
    .ready   (ready),
    .ctrl    (ctrl),
    .stat    (stat)
  );

  swma_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .push_value   (request.push_value),
    .valid        (response.valid),
    .ready        (response.ready),
    .status       (response.status),
    .result_value (response.result_value),
    .depth_after  (response.depth_after)
  );

endmodule

>>> design/swma_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module swma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/swma_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_datapath
// Entry RAM, entry count, shift index and the response register.
// ---------------------------------------------------------------------------
module swma_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  swma_pkg::dp_ctrl_t                  ctrl,
  output swma_pkg::dp_stat_t                  stat,
  input  logic signed [swma_pkg::VALUE_W-1:0] push_value,
  output logic                                valid,
  input  logic                                ready,
  output logic [swma_pkg::STATUS_W-1:0]       status,
  output logic signed [swma_pkg::VALUE_W-1:0] result_value,
  output logic [swma_pkg::DEPTH_W-1:0]        depth_after
);

  logic [swma_pkg::COUNT_W-1:0] count;
  logic [swma_pkg::COUNT_W-1:0] count_next;
  logic [swma_pkg::ADDR_W-1:0]  ptr;
  logic [swma_pkg::ADDR_W-1:0]  ptr_next;
  logic                         we;
  logic [swma_pkg::ADDR_W-1:0]  waddr;
  logic [swma_pkg::VALUE_W-1:0] wdata;
  logic [swma_pkg::ADDR_W-1:0]  raddr;
  logic [swma_pkg::VALUE_W-1:0] rdata;

  always_comb begin
    count_next = count;
    if (ctrl.push_write) begin
      count_next = count + swma_pkg::COUNT_W'(1);
    end else if (ctrl.pop_read || ctrl.count_down) begin
      count_next = count - swma_pkg::COUNT_W'(1);
    end
  end

  always_comb begin
    ptr_next = ptr;
    if (ctrl.mid_read) begin
      ptr_next = swma_pkg::ADDR_W'(count >> 1);
    end else if (ctrl.shift_write) begin
      ptr_next = ptr + swma_pkg::ADDR_W'(1);
    end
  end

  // During a shift, fetch the entry two above the slot being written
  always_comb begin
    priority if (ctrl.pop_read) begin
      raddr = swma_pkg::ADDR_W'(count - swma_pkg::COUNT_W'(1));
    end else if (ctrl.mid_read) begin
      raddr = swma_pkg::ADDR_W'(count >> 1);
    end else if (ctrl.shift_write) begin
      raddr = ptr + swma_pkg::ADDR_W'(2);
    end else begin
      raddr = ptr + swma_pkg::ADDR_W'(1);
    end
  end

  assign we    = ctrl.push_write || ctrl.shift_write;
  assign waddr = ctrl.push_write ? swma_pkg::ADDR_W'(count) : ptr;
  assign wdata = ctrl.push_write ? push_value : rdata;

  swma_ram #(
    .WIDTH (swma_pkg::VALUE_W),
    .DEPTH (swma_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctrl.load_result) begin
        valid <= 1'b1;
      end else if (ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (ctrl.load_result) begin
      status       <= ctrl.res_status;
      result_value <= ctrl.res_from_ram ? rdata : '0;
      depth_after  <= swma_pkg::DEPTH_W'(count_next);
    end
  end

  always_comb begin
    stat.empty    = (count == '0);
    stat.full     = (count == swma_pkg::COUNT_W'(swma_pkg::STACK_DEPTH));
    stat.more     = ((swma_pkg::COUNT_W'(ptr) + swma_pkg::COUNT_W'(1)) < count);
    stat.out_busy = valid && !ready;
  end

endmodule

>>> design/swma_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_controller
// Command sequencer: accept, RAM fetch and the shift sweep of a middle delete.
// ---------------------------------------------------------------------------
module swma_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic [swma_pkg::CMD_W-1:0]  command,
  output logic                        ready,
  output swma_pkg::dp_ctrl_t          ctrl,
  input  swma_pkg::dp_stat_t          stat
);

  swma_pkg::state_t state;
  swma_pkg::state_t state_next;
  swma_pkg::cmd_t   cmd_in;
  swma_pkg::cmd_t   cmd_pend;
  logic             accept;

  assign cmd_in = swma_pkg::cmd_t'(command);
  assign ready  = (state == swma_pkg::S_IDLE) && !stat.out_busy;
  assign accept = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_pend <= cmd_in;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swma_pkg::S_IDLE: begin
        if (accept && cmd_in != swma_pkg::CMD_PUSH && !stat.empty) begin
          state_next = swma_pkg::S_FETCH;
        end
      end
      swma_pkg::S_FETCH: begin
        if (cmd_pend == swma_pkg::CMD_DELETE_MID && stat.more) begin
          state_next = swma_pkg::S_SHIFT;
        end else begin
          state_next = swma_pkg::S_IDLE;
        end
      end
      swma_pkg::S_SHIFT: begin
        if (!stat.more) begin
          state_next = swma_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swma_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.res_status = swma_pkg::RS_OK;
    unique case (state)
      swma_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_in == swma_pkg::CMD_PUSH) begin
            ctrl.load_result = 1'b1;
            if (stat.full) begin
              ctrl.res_status = swma_pkg::RS_FULL;
            end else begin
              ctrl.push_write = 1'b1;
            end
          end else if (stat.empty) begin
            ctrl.load_result = 1'b1;
            ctrl.res_status  = swma_pkg::RS_EMPTY;
          end else if (cmd_in == swma_pkg::CMD_POP) begin
            ctrl.pop_read = 1'b1;
          end else begin
            ctrl.mid_read = 1'b1;
          end
        end
      end
      swma_pkg::S_FETCH: begin
        ctrl.load_result  = 1'b1;
        ctrl.res_from_ram = 1'b1;
        ctrl.count_down   = (cmd_pend == swma_pkg::CMD_DELETE_MID);
      end
      swma_pkg::S_SHIFT: begin
        ctrl.shift_write = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

>>> design/swma_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swma_checker
// Port-level checks of the stack core, attached by bind.
// ---------------------------------------------------------------------------
module swma_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic [swma_pkg::CMD_W-1:0]          req_command,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [swma_pkg::STATUS_W-1:0]       rsp_status,
  input logic signed [swma_pkg::VALUE_W-1:0] rsp_value,
  input logic [swma_pkg::DEPTH_W-1:0]        rsp_depth
);

  // No response beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response holds its beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_value) && $stable(rsp_depth))
    else $error("stalled response changed");

  // A push answers in the next cycle
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == swma_pkg::CMD_PUSH |=> rsp_valid)
    else $error("push response missing");

  // No new command while a response is stalled
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

  // A refused push reports a full stack
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == swma_pkg::RS_FULL |->
      rsp_depth == swma_pkg::DEPTH_W'(swma_pkg::STACK_DEPTH) && rsp_value == '0)
    else $error("full status with wrong depth or value");

endmodule

bind stack_with_middle_access_core swma_checker u_swma_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .rsp_status  (response.status),
  .rsp_value   (response.result_value),
  .rsp_depth   (response.depth_after)
);
